### src/itaf_pkg.sv
package itaf_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CNT_W = 6;
  localparam int unsigned IDX_W = 5;
  localparam int unsigned DEC_DIGITS = 10;
  localparam int unsigned BCD_W = 4 * DEC_DIGITS;
  localparam int unsigned HEX_DIGITS = 8;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned MAX_BIN_DIGITS_DEF = 32;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_A = 8'd65;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

  typedef enum logic [1:0] {
    REQ_UDEC,
    REQ_SDEC,
    REQ_HEX,
    REQ_BIN
  } req_e;

  typedef struct packed {
    logic load;
    logic conv;
    logic skip;
    logic emit;
    logic emit_sign;
  } itaf_cmd_t;

  typedef struct packed {
    req_e mode;
    logic neg;
    logic cnt_zero;
    logic cnt_one;
    logic top_zero;
  } itaf_sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] r;
    if (d > 4'd9) begin
      r = ASCII_A + {4'd0, d} - 8'd10;
    end else begin
      r = ASCII_ZERO + {4'd0, d};
    end
    return r;
  endfunction

endpackage

### src/itaf_datapath.sv
module itaf_datapath import itaf_pkg::*; #(
  parameter int unsigned MaxBinDigits = MAX_BIN_DIGITS_DEF
) (
  input  logic               clk_i,
  input  req_e               in_type_i,
  input  logic [VALUE_W-1:0] in_value_i,
  input  logic [CNT_W-1:0]   in_bin_digits_i,
  input  itaf_cmd_t          cmd_i,
  output itaf_sts_t          sts_o,
  output logic [CHAR_W-1:0]  char_o,
  output logic               last_o
);

  localparam int unsigned BinCap = (MaxBinDigits > VALUE_W) ? VALUE_W : MaxBinDigits;
  localparam logic [CNT_W-1:0] BinCapC = CNT_W'(BinCap);

  req_e               mode_q;
  logic               neg_q;
  logic [VALUE_W-1:0] src_q;
  logic [BCD_W-1:0]   bcd_q;
  logic [BCD_W-1:0]   bcd_adj;
  logic [CNT_W-1:0]   cnt_q;
  logic [CNT_W-1:0]   cnt_m1;
  logic [CNT_W-1:0]   bin_cnt;
  logic [CHAR_W-1:0]  char_q;
  logic               last_q;
  logic               in_neg;

  assign in_neg = (in_type_i == REQ_SDEC) && in_value_i[VALUE_W-1];
  assign cnt_m1 = cnt_q - 1'b1;
  assign bin_cnt = (in_bin_digits_i > BinCapC) ? BinCapC : in_bin_digits_i;

  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= in_type_i;
      neg_q  <= in_neg;
      src_q  <= in_neg ? (~in_value_i + 1'b1) : in_value_i;
      case (in_type_i)
        REQ_HEX: begin
          bcd_q <= {in_value_i, {(BCD_W - VALUE_W){1'b0}}};
          cnt_q <= CNT_W'(HEX_DIGITS);
        end
        REQ_BIN: begin
          bcd_q <= '0;
          cnt_q <= bin_cnt;
        end
        default: begin
          bcd_q <= '0;
          cnt_q <= CNT_W'(VALUE_W);
        end
      endcase
    end else if (cmd_i.conv) begin
      bcd_q <= {bcd_adj[BCD_W-2:0], src_q[VALUE_W-1]};
      src_q <= {src_q[VALUE_W-2:0], 1'b0};
      cnt_q <= (cnt_q == CNT_W'(1)) ? CNT_W'(DEC_DIGITS) : cnt_m1;
    end else if (cmd_i.skip) begin
      bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
      cnt_q <= cnt_m1;
    end else if (cmd_i.emit) begin
      bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
      cnt_q <= cnt_m1;
    end
    if (cmd_i.emit_sign) begin
      char_q <= ASCII_MINUS;
      last_q <= 1'b0;
    end else if (cmd_i.emit) begin
      if (mode_q == REQ_BIN) begin
        char_q <= ASCII_ZERO + {7'd0, src_q[cnt_m1[IDX_W-1:0]]};
      end else begin
        char_q <= digit_char(bcd_q[BCD_W-1 -: 4]);
      end
      last_q <= (cnt_q == CNT_W'(1));
    end
  end

  assign sts_o.mode     = mode_q;
  assign sts_o.neg      = neg_q;
  assign sts_o.cnt_zero = (cnt_q == '0);
  assign sts_o.cnt_one  = (cnt_q == CNT_W'(1));
  assign sts_o.top_zero = (bcd_q[BCD_W-1 -: 4] == 4'd0);
  assign char_o = char_q;
  assign last_o = last_q;

endmodule

### src/itaf_ctrl.sv
module itaf_ctrl import itaf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  itaf_sts_t sts_i,
  output itaf_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SIGN,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   out_valid_q;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts_i.mode == REQ_BIN) begin
          state_d = sts_i.cnt_zero ? ST_IDLE : ST_EMIT;
        end else if (sts_i.mode == REQ_HEX) begin
          state_d = ST_SKIP;
        end else if (sts_i.neg) begin
          state_d = ST_SIGN;
        end else begin
          state_d = ST_CONV;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.conv = 1'b1;
        if (sts_i.cnt_one) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (sts_i.top_zero && !sts_i.cnt_one) begin
          cmd_o.skip = 1'b1;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.cnt_one) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.emit || cmd_o.emit_sign) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### src/integer_to_ascii_formatter_core.sv
// Channel  Direction  Payload
// s_axis   in         tuser: req_type[1:0]; tdata: value[31:0], bin_digits[37:32]
// m_axis   out        tdata: char_code[7:0]; tlast: last_char
//
// A request is loaded and dispatched, then its characters are emitted in turn.
// Decimal first runs a shift-and-add-3 conversion over all 32 bits and drops up to 9
// leading zeros; hex drops up to 7. Both then leave the zero skip for the emit state.
// A binary request emits its digits with no conversion or zero skip.
// Reset returns the controller to idle and clears the output valid.
// A stalled output holds its character and pauses the controller before its next character.
module integer_to_ascii_formatter_core import itaf_pkg::*; #(
  parameter int unsigned MAX_BIN_DIGITS = MAX_BIN_DIGITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // value[31:0], bin_digits[37:32], zero pad
  input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // char_code[7:0]
  output logic        m_axis_tlast
);

  itaf_cmd_t cmd;
  itaf_sts_t sts;

  itaf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  itaf_datapath #(
    .MaxBinDigits(MAX_BIN_DIGITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .in_type_i      (req_e'(s_axis_tuser)),
    .in_value_i     (s_axis_tdata[31:0]),
    .in_bin_digits_i(s_axis_tdata[37:32]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .char_o         (m_axis_tdata),
    .last_o         (m_axis_tlast)
  );

`ifndef SYNTHESIS
  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit || cmd.emit_sign) |-> (!m_axis_tvalid || m_axis_tready))
    else $error("character emitted over a pending one");

  a_conv_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.conv |-> !sts.cnt_zero)
    else $error("conversion counter underflow");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && sts.cnt_one) |=> (m_axis_tvalid && m_axis_tlast))
    else $error("final character lacks tlast");

  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_sign |=> (m_axis_tvalid && !m_axis_tlast))
    else $error("sign character marked last");
`endif

endmodule

### tb/sv/itaf_stream_checker.sv
module itaf_stream_checker import itaf_pkg::*; #(
  parameter int unsigned MAX_BIN_DIGITS = MAX_BIN_DIGITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [39:0]       s_axis_tdata,  // value[31:0], bin_digits[37:32], zero pad
  input  logic [1:0]        s_axis_tuser,  // req_type[1:0]
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [7:0]        m_axis_tdata,  // char_code[7:0]
  input  logic              m_axis_tlast,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEC_RADIX = 10;
  localparam int unsigned HEX_RADIX = 16;
  localparam int unsigned BIN_CAP = (MAX_BIN_DIGITS > VALUE_W) ? VALUE_W : MAX_BIN_DIGITS;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } ascii_char_t;

  ascii_char_t expected_chars[$];

  function automatic void push_digits(input logic [VALUE_W-1:0] mag, input int unsigned radix);
    logic [CHAR_W-1:0] digs[$];
    logic [VALUE_W-1:0] d;
    ascii_char_t c;
    do begin
      d = mag % radix;
      digs.push_front((d > 9) ? ASCII_A + d[7:0] - 8'd10 : ASCII_ZERO + d[7:0]);
      mag = mag / radix;
    end while (mag != 0);
    foreach (digs[i]) begin
      c.code = digs[i];
      c.last = (i == digs.size() - 1);
      expected_chars.push_back(c);
    end
  endfunction

  function automatic void predict_chars(input req_e mode, input logic [VALUE_W-1:0] value,
                                        input logic [CNT_W-1:0] digits);
    int unsigned count;
    ascii_char_t c;
    case (mode)
      REQ_UDEC: begin
        push_digits(value, DEC_RADIX);
      end
      REQ_SDEC: begin
        if (value[VALUE_W-1]) begin
          c.code = ASCII_MINUS;
          c.last = 1'b0;
          expected_chars.push_back(c);
          push_digits(~value + 32'd1, DEC_RADIX);
        end else begin
          push_digits(value, DEC_RADIX);
        end
      end
      REQ_HEX: begin
        push_digits(value, HEX_RADIX);
      end
      default: begin
        count = (digits > BIN_CAP) ? BIN_CAP : digits;
        for (int i = count; i > 0; i--) begin
          c.code = ASCII_ZERO + {7'd0, value[i-1]};
          c.last = (i == 1);
          expected_chars.push_back(c);
        end
      end
    endcase
  endfunction

  always @(posedge clk_i) begin
    ascii_char_t want;
    if (!rst_ni) begin
      fail_count_o = 0;
      pending_o = 0;
      expected_chars.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_chars(req_e'(s_axis_tuser), s_axis_tdata[31:0], s_axis_tdata[37:32]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected character: expected none, actual code %h last %b",
                   $time, m_axis_tdata, m_axis_tlast);
          fail_count_o++;
        end else begin
          want = expected_chars.pop_front();
          if (m_axis_tdata !== want.code) begin
            $display("%0t: char_code mismatch: expected %h, actual %h",
                     $time, want.code, m_axis_tdata);
            fail_count_o++;
          end
          if (m_axis_tlast !== want.last) begin
            $display("%0t: last_char mismatch: expected %b, actual %b",
                     $time, want.last, m_axis_tlast);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_chars.size();
    end
  end

endmodule

### tb/sv/integer_to_ascii_formatter_core_tb.sv
module integer_to_ascii_formatter_core_tb import itaf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned IDLE_PCT = 18;
  localparam int unsigned RANDOM_REQUESTS = 388;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // value[31:0], bin_digits[37:32], zero pad
  logic [1:0]  s_axis_tuser = '0;  // req_type[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;  // char_code[7:0]
  logic        m_axis_tlast;

  logic        idle_on = 1'b1;
  int unsigned cycle_count = 0;
  int unsigned fail_count;
  int unsigned pending;

  integer_to_ascii_formatter_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  itaf_stream_checker u_char_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic send_request(input req_e mode, input logic [31:0] value,
                              input logic [5:0] digits);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, digits, value};
    s_axis_tuser <= mode;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
  endtask

  task automatic send_random_request();
    req_e mode;
    logic [31:0] value;
    logic [5:0] digits;
    mode = req_e'($urandom_range(3));
    value = $urandom;
    if ($urandom_range(3) != 0) begin
      value = value >> $urandom_range(31);
    end
    if (mode == REQ_SDEC && $urandom_range(1) == 1) begin
      value = ~value + 32'd1;
    end
    if ($urandom_range(7) == 0) begin
      digits = 6'($urandom_range(63));
    end else begin
      digits = 6'($urandom_range(32, 1));
    end
    send_request(mode, value, digits);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_request(REQ_UDEC, 32'd0, 6'd5);
    send_request(REQ_UDEC, 32'hFFFF_FFFF, 6'd63);
    send_request(REQ_UDEC, 32'd9, 6'd1);
    send_request(REQ_UDEC, 32'd10, 6'd0);
    send_request(REQ_UDEC, 32'd1_000_000_000, 6'd32);
    send_request(REQ_SDEC, 32'h8000_0000, 6'd1);
    send_request(REQ_SDEC, 32'hFFFF_FFFF, 6'd2);
    send_request(REQ_SDEC, 32'h7FFF_FFFF, 6'd3);
    send_request(REQ_SDEC, 32'd0, 6'd4);
    send_request(REQ_SDEC, 32'hFFFF_FFF6, 6'd63);
    send_request(REQ_HEX, 32'd0, 6'd0);
    send_request(REQ_HEX, 32'hFFFF_FFFF, 6'd63);
    send_request(REQ_HEX, 32'h0000_000A, 6'd7);
    send_request(REQ_HEX, 32'h1234_5678, 6'd21);
    send_request(REQ_HEX, 32'h9ABC_DEF0, 6'd42);
    send_request(REQ_BIN, 32'hFFFF_FFFF, 6'd0);
    send_request(REQ_BIN, 32'h0000_0001, 6'd1);
    send_request(REQ_BIN, 32'h0000_0000, 6'd1);
    send_request(REQ_BIN, 32'hA5A5_A5A5, 6'd32);
    send_request(REQ_BIN, 32'h5A5A_5A5A, 6'd33);
    send_request(REQ_BIN, 32'hFFFF_FFFF, 6'd63);
    send_request(REQ_BIN, 32'h0001_5555, 6'd17);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      idle_on <= !(n >= 120 && n < 220);
      send_random_request();
    end
    s_axis_tvalid <= 1'b0;

    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
src/itaf_pkg.sv
src/itaf_datapath.sv
src/itaf_ctrl.sv
src/integer_to_ascii_formatter_core.sv
tb/sv/itaf_stream_checker.sv
tb/sv/integer_to_ascii_formatter_core_tb.sv
